// File: rtl/assert_macros.svh
// assertion macros shared by the rtl files
// depends on nothing; included where assertions are written
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked every clock edge outside reset
`define CHECK_ALWAYS(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// implication checked every clock edge outside reset
`define CHECK_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/lzw_pkg.sv
`timescale 1ns / 1ps
// package for the lzw encoder: widths, codes and shared types
// depends on nothing
package lzw_pkg;
  localparam int MAX_CODE_BITS = 14;
  localparam int MIN_CODE_BITS = 9;
  localparam int BYTE_W = 8;
  localparam int WID_W = 4;
  localparam int DICT_DEPTH = 1 << MAX_CODE_BITS;
  localparam logic [MAX_CODE_BITS-1:0] FIRST_CODE = MAX_CODE_BITS'(256);
  localparam logic [MAX_CODE_BITS-1:0] CLEAR_CODE = {MAX_CODE_BITS{1'b1}};
  localparam logic [WID_W-1:0] MIN_WIDTH = WID_W'(MIN_CODE_BITS);
  localparam logic [WID_W-1:0] MAX_WIDTH = WID_W'(MAX_CODE_BITS);

  typedef struct packed {
    logic              eos;
    logic [BYTE_W-1:0] data;
  } item_t;

  typedef struct packed {
    logic full;
    logic busy;
  } lzw_status_t;

  // all-ones value of a code width
  function automatic logic [MAX_CODE_BITS-1:0] ones_of(input logic [WID_W-1:0] w);
    logic [MAX_CODE_BITS:0] t;
    t = ((MAX_CODE_BITS+1)'(1) << w) - (MAX_CODE_BITS+1)'(1);
    return t[MAX_CODE_BITS-1:0];
  endfunction
endpackage

// File: rtl/lzw_if.sv
`timescale 1ns / 1ps
// channel interfaces for byte input and code output
// depends on lzw_pkg
interface lzw_in_if import lzw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              end_of_stream;
  modport source (output valid, data_byte, end_of_stream, input ready);
  modport sink (input valid, data_byte, end_of_stream, output ready);
endinterface

interface lzw_out_if import lzw_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [MAX_CODE_BITS-1:0] code_value;
  logic [WID_W-1:0]         code_width;
  logic                     run_last;
  modport source (output valid, code_value, code_width, run_last, input ready);
  modport sink (input valid, code_value, code_width, run_last, output ready);
endinterface

// File: rtl/lzw_variable_width_encoder_top.sv
`timescale 1ns / 1ps
// top level of the lzw encoder: input queue, dictionary engine, checks
// depends on lzw_pkg, lzw_if, lzw_front, lzw_core, assert_macros.svh
//
// lzw encoder with variable code widths (9 to 14 bits, bit packing not done
// here). bytes enter on in_ch, one per transfer, end_of_stream marking the last
// byte of a stream; codes leave on out_ch with their width and run_last on
// the final code caused by a byte. a two-entry queue takes bytes while the
// engine works. the engine dequeues a byte only while it is idle; a byte that
// only starts the prefix needs nothing more. otherwise the child-list head is
// read (skipped for a literal prefix with no children yet), then each node on
// the sibling chain is visited in turn until a hit or the end of the chain. a
// miss then writes the new node and the new code's empty child-list head and
// emits up to three codes, one per cycle while the receiver does not stall.
// the sibling chain walk in the dictionary memory sets the rate.
// no clearing pass is needed after reset: literal codes carry valid bits and
// all other entries are initialized when they are inserted.
module lzw_variable_width_encoder_top import lzw_pkg::*; (
  input logic       clk,
  input logic       rst,
  lzw_in_if.sink    in_ch,
  lzw_out_if.source out_ch
);
  `include "assert_macros.svh"

  item_t       in_item;
  item_t       item;
  logic        item_valid;
  logic        item_pop;
  lzw_status_t status;

  assign in_item = '{eos: in_ch.end_of_stream, data: in_ch.data_byte};

  // front: buffers incoming byte transfers
  lzw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item_pop   (item_pop),
    .item       (item),
    .full       (status.full)
  );

  // back: dictionary search, insert and code output
  lzw_core u_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_code   (out_ch.code_value),
    .out_width  (out_ch.code_width),
    .out_last   (out_ch.run_last),
    .busy       (status.busy)
  );

  // code widths stay in range
  `CHECK_IMPLY(a_width_range, clk, rst, out_ch.valid,
    out_ch.code_width >= MIN_WIDTH && out_ch.code_width <= MAX_WIDTH)
  // the clear code always ends the codes of its byte
  `CHECK_IMPLY(a_clear_last, clk, rst,
    out_ch.valid && out_ch.code_value == CLEAR_CODE && out_ch.code_width == MAX_WIDTH,
    out_ch.run_last)
  // a full queue refuses bytes
  `CHECK_IMPLY(a_full_stall, clk, rst, status.full, !in_ch.ready)
  // a busy engine takes no byte from the queue
  `CHECK_IMPLY(a_busy_no_pop, clk, rst, status.busy, !item_pop)
endmodule

// File: rtl/lzw_front.sv
`timescale 1ns / 1ps
// front end: two-entry input queue decoupling the byte source from the engine
// depends on lzw_pkg
module lzw_front import lzw_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  item_valid,
  input  logic  item_pop,
  output item_t item,
  output logic  full
);
  item_t      slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready   = (count != 2'd2);
  assign full       = (count == 2'd2);
  assign item_valid = (count != 2'd0);
  assign item       = slot[rd_ptr];
  assign push       = in_valid && in_ready;
  assign pop        = item_pop && item_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_item;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule

// File: rtl/lzw_core.sv
`timescale 1ns / 1ps
// back end: dictionary walk, insert, code emission and output register
// depends on lzw_pkg
module lzw_core import lzw_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     item_valid,
  input  item_t                    item,
  output logic                     item_pop,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [MAX_CODE_BITS-1:0] out_code,
  output logic [WID_W-1:0]         out_width,
  output logic                     out_last,
  output logic                     busy
);
  localparam int CW = MAX_CODE_BITS;
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_HEAD = 3'd1;
  localparam logic [2:0] S_NODE = 3'd2;
  localparam logic [2:0] S_MISS = 3'd3;
  localparam logic [2:0] S_ADD2 = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  // head entry {none, first child}; node entry {none, sibling, byte}
  logic [CW:0]          head_mem [DICT_DEPTH];
  logic [CW+BYTE_W:0]   node_mem [DICT_DEPTH];
  logic [CW:0]          head_q;
  logic [CW+BYTE_W:0]   node_q;
  logic [CW-1:0]        node_addr;
  logic [CW-1:0]        node_addr_r;
  logic                 lit_valid [256];

  logic [2:0]           state;
  logic [CW-1:0]        prefix;
  logic                 prefix_valid;
  logic [CW-1:0]        next_code;
  logic [WID_W-1:0]     cur_width;
  logic [BYTE_W-1:0]    cur_byte;
  logic                 cur_eos;
  logic [CW:0]          old_head;
  logic [CW-1:0]        add_code;
  logic [CW-1:0]        res_val [3];
  logic [WID_W-1:0]     res_w [3];
  logic [1:0]           res_n;
  logic [1:0]           res_i;
  logic                 out_load;

  assign node_addr = (state == S_HEAD) ? head_q[CW-1:0] : node_q[CW+BYTE_W-1:BYTE_W];
  assign item_pop  = (state == S_IDLE);
  assign busy      = (state != S_IDLE);
  assign out_load  = (state == S_EMIT) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    head_q <= head_mem[prefix];
    node_q <= node_mem[node_addr];
    if (state == S_MISS) begin
      node_mem[next_code] <= {old_head, cur_byte};
      head_mem[prefix]    <= {1'b0, next_code};
    end else if (state == S_ADD2) begin
      head_mem[add_code] <= {1'b1, {CW{1'b0}}};
    end
  end

  // code of the node currently presented on the node read port
  always_ff @(posedge clk) begin
    node_addr_r <= node_addr;
  end

  always_ff @(posedge clk) begin
    logic [CW-1:0] nc1;
    logic          clr;
    logic          grow;
    logic [WID_W-1:0] w2;
    logic          restart;
    nc1     = next_code + CW'(1);
    clr     = (nc1 >= CLEAR_CODE);
    grow    = !clr && (nc1 >= ones_of(cur_width));
    w2      = (grow && cur_width < MAX_WIDTH) ? cur_width + WID_W'(1) : cur_width;
    restart = 1'b0;
    if (out_load) begin
      out_code  <= res_val[res_i];
      out_width <= res_w[res_i];
      out_last  <= (res_i == res_n - 2'd1);
    end
    if (rst) begin
      state        <= S_IDLE;
      prefix       <= '0;
      prefix_valid <= 1'b0;
      next_code    <= FIRST_CODE;
      cur_width    <= MIN_WIDTH;
      out_valid    <= 1'b0;
      res_n        <= 2'd0;
      res_i        <= 2'd0;
      for (int i = 0; i < 256; i++) lit_valid[i] <= 1'b0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            cur_byte <= item.data;
            cur_eos  <= item.eos;
            res_i    <= 2'd0;
            if (!prefix_valid) begin
              // empty prefix: the byte starts it, flushed at once on end of stream
              if (item.eos) begin
                res_val[0] <= CW'(item.data);
                res_w[0]   <= cur_width;
                res_n      <= 2'd1;
                restart    = 1'b1;
                state      <= S_EMIT;
              end else begin
                prefix       <= CW'(item.data);
                prefix_valid <= 1'b1;
              end
            end else if (prefix < FIRST_CODE && !lit_valid[prefix[BYTE_W-1:0]]) begin
              old_head <= {1'b1, {CW{1'b0}}};
              state    <= S_MISS;
            end else begin
              state <= S_HEAD;
            end
          end
        end
        S_HEAD: begin
          old_head <= head_q;
          state    <= head_q[CW] ? S_MISS : S_NODE;
        end
        S_NODE: begin
          if (node_q[BYTE_W-1:0] == cur_byte) begin
            // hit: the matched code becomes the prefix, or is emitted on end of stream
            if (cur_eos) begin
              res_val[0] <= node_addr_r;
              res_w[0]   <= cur_width;
              res_n      <= 2'd1;
              restart    = 1'b1;
              state      <= S_EMIT;
            end else begin
              prefix <= node_addr_r;
              state  <= S_IDLE;
            end
          end else if (node_q[CW+BYTE_W]) begin
            state <= S_MISS;
          end
        end
        S_MISS: begin
          restart    = clr || cur_eos;
          add_code   <= next_code;
          res_val[0] <= prefix;
          res_w[0]   <= cur_width;
          if (!restart) begin
            next_code <= nc1;
            if (prefix < FIRST_CODE) lit_valid[prefix[BYTE_W-1:0]] <= 1'b1;
          end
          if (clr) begin
            res_val[1] <= CW'(cur_byte);
            res_w[1]   <= cur_width;
            res_val[2] <= CLEAR_CODE;
            res_w[2]   <= MAX_WIDTH;
            res_n      <= 2'd3;
          end else if (grow) begin
            res_val[1] <= ones_of(cur_width);
            res_w[1]   <= cur_width;
            res_val[2] <= CW'(cur_byte);
            res_w[2]   <= w2;
            res_n      <= cur_eos ? 2'd3 : 2'd2;
            if (!cur_eos) begin
              cur_width <= w2;
              prefix    <= CW'(cur_byte);
            end
          end else begin
            res_val[1] <= CW'(cur_byte);
            res_w[1]   <= cur_width;
            res_n      <= cur_eos ? 2'd2 : 2'd1;
            if (!cur_eos) prefix <= CW'(cur_byte);
          end
          state <= S_ADD2;
        end
        S_ADD2: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_load) begin
            res_i <= res_i + 2'd1;
            if (res_i == res_n - 2'd1) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (restart) begin
        prefix       <= '0;
        prefix_valid <= 1'b0;
        next_code    <= FIRST_CODE;
        cur_width    <= MIN_WIDTH;
        for (int i = 0; i < 256; i++) lit_valid[i] <= 1'b0;
      end
    end
  end
endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for the lzw variable-width encoder
// depends on lzw_pkg, lzw_if and lzw_variable_width_encoder_top
module testbench;
  import lzw_pkg::*;

  // one expected code with its width and run_last flag
  typedef struct packed {
    logic [MAX_CODE_BITS-1:0] value;
    logic [WID_W-1:0]         width;
    logic                     last;
  } code_t;

  // directed row: input byte, end flag, and an optional typed-in expectation
  typedef struct packed {
    logic [7:0]  data;
    logic        eos;
    logic        typed;
    logic [1:0]  n;
    code_t [2:0] codes;
  } row_t;

  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 40;

  logic clk;
  logic rst;
  lzw_in_if  in_ch();
  lzw_out_if out_ch();

  lzw_variable_width_encoder_top dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch)
  );

  // encoder mirror: prefix, free code, width and a pair table
  logic [MAX_CODE_BITS-1:0] cur_prefix;
  logic                     have_prefix;
  logic [MAX_CODE_BITS-1:0] free_code;
  logic [WID_W-1:0]         cur_width;
  int                       pair_code [int];

  code_t expected_codes [$];
  int    errors;
  int    send_idle_pct;
  int    recv_stall_pct;
  int    quiet_cycles;
  code_t typed_codes [$];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int pair_key(logic [MAX_CODE_BITS-1:0] p, logic [7:0] b);
    return (int'(p) << 8) | int'(b);
  endfunction

  task automatic restart_dictionary();
    pair_code.delete();
    free_code = FIRST_CODE;
    cur_width = MIN_WIDTH;
    cur_prefix = '0;
    have_prefix = 1'b0;
  endtask

  task automatic push_code(logic [MAX_CODE_BITS-1:0] v, logic [WID_W-1:0] w);
    code_t c;
    c.value = v;
    c.width = w;
    c.last = 1'b0;
    expected_codes.push_back(c);
  endtask

  // encode one byte into expected codes
  task automatic encode_byte(logic [7:0] b, logic eos);
    int first;
    int key;
    logic [MAX_CODE_BITS:0] ones;
    first = expected_codes.size();
    if (!have_prefix) begin
      cur_prefix = MAX_CODE_BITS'(b);
      have_prefix = 1'b1;
    end else begin
      key = pair_key(cur_prefix, b);
      if (pair_code.exists(key)) begin
        cur_prefix = MAX_CODE_BITS'(pair_code[key]);
      end else begin
        push_code(cur_prefix, cur_width);
        pair_code[key] = int'(free_code);
        free_code = free_code + 1'b1;
        if (free_code >= CLEAR_CODE) begin
          // dictionary full: byte code, then clear code
          push_code(MAX_CODE_BITS'(b), cur_width);
          push_code(CLEAR_CODE, MAX_WIDTH);
          restart_dictionary();
        end else begin
          ones = ((MAX_CODE_BITS+1)'(1) << cur_width) - (MAX_CODE_BITS+1)'(1);
          if (free_code >= ones) begin
            // grow marker
            push_code(ones[MAX_CODE_BITS-1:0], cur_width);
            if (cur_width < MAX_WIDTH) cur_width = cur_width + 1'b1;
          end
          cur_prefix = MAX_CODE_BITS'(b);
        end
      end
    end
    if (eos) begin
      if (have_prefix) push_code(cur_prefix, cur_width);
      restart_dictionary();
    end
    if (expected_codes.size() > first)
      expected_codes[expected_codes.size()-1].last = 1'b1;
  endtask

  // one input transfer; the predictor runs when it is accepted
  task automatic send_byte(logic [7:0] b, logic eos);
    while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.end_of_stream <= eos;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    encode_byte(b, eos);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (expected_codes.size() != 0) @(negedge clk);
  endtask

  // receiver stalls
  always @(negedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else out_ch.ready <= !(recv_stall_pct > 0 && $urandom_range(99, 0) < recv_stall_pct);
  end

  // result check at the rising edge, plus the watchdog
  always @(posedge clk) begin
    code_t exp_c;
    if (!rst) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_codes.size() == 0) begin
          $display("%0t: unexpected code %0d/%0d/%0b", $time, out_ch.code_value,
                   out_ch.code_width, out_ch.run_last);
          errors++;
        end else begin
          exp_c = expected_codes.pop_front();
          if (out_ch.code_value !== exp_c.value || out_ch.code_width !== exp_c.width ||
              out_ch.run_last !== exp_c.last) begin
            $display("%0t: expected %0d/%0d/%0b actual %0d/%0d/%0b", $time,
                     exp_c.value, exp_c.width, exp_c.last, out_ch.code_value,
                     out_ch.code_width, out_ch.run_last);
            errors++;
          end
          // typed-in rows check the predictor too
          if (typed_codes.size() != 0) begin
            if (typed_codes[0] !== exp_c) begin
              $display("%0t: expected %0d/%0d/%0b actual %0d/%0d/%0b", $time,
                       typed_codes[0].value, typed_codes[0].width, typed_codes[0].last,
                       exp_c.value, exp_c.width, exp_c.last);
              errors++;
            end
            void'(typed_codes.pop_front());
          end
        end
      end
    end
  end

  function automatic code_t mk(int v, int w, bit l);
    code_t c;
    c.value = MAX_CODE_BITS'(v);
    c.width = WID_W'(w);
    c.last = l;
    return c;
  endfunction

  row_t rows [$];
  row_t r;
  int   i;
  int   phase;
  int   j;
  logic [7:0] alpha;

  initial begin
    errors = 0;
    quiet_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.end_of_stream = 1'b0;
    out_ch.ready = 1'b0;
    restart_dictionary();
    rst = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed rows: empty prefix, miss, hit, flush, lone byte, extremes
    r = '0; r.data = 8'h00; r.typed = 1'b1; r.n = 2'd0; rows.push_back(r);
    r = '0; r.data = 8'hff; r.typed = 1'b1; r.n = 2'd1; r.codes[0] = mk(0, 9, 1);
    rows.push_back(r);
    r = '0; r.data = 8'h00; r.typed = 1'b1; r.n = 2'd1; r.codes[0] = mk(255, 9, 1);
    rows.push_back(r);
    r = '0; r.data = 8'hff; r.typed = 1'b1; r.n = 2'd0; rows.push_back(r);
    r = '0; r.data = 8'h00; r.eos = 1'b1; r.typed = 1'b1; r.n = 2'd2;
    r.codes[0] = mk(256, 9, 0); r.codes[1] = mk(0, 9, 1); rows.push_back(r);
    r = '0; r.data = 8'haa; r.eos = 1'b1; r.typed = 1'b1; r.n = 2'd1;
    r.codes[0] = mk(170, 9, 1);
    rows.push_back(r);
    r = '0; r.data = 8'h55; rows.push_back(r);
    r = '0; r.data = 8'h55; rows.push_back(r);
    r = '0; r.data = 8'h55; rows.push_back(r);
    r = '0; r.data = 8'h55; rows.push_back(r);
    r = '0; r.data = 8'h55; r.eos = 1'b1; rows.push_back(r);
    foreach (rows[k]) begin
      if (rows[k].typed)
        for (j = 0; j < int'(rows[k].n); j++) typed_codes.push_back(rows[k].codes[j]);
      send_byte(rows[k].data, rows[k].eos);
      wait_drained();
    end

    // full-alphabet run: almost every byte misses, reaching the first grow marker
    for (i = 0; i < 290; i++) send_byte(8'($urandom_range(255, 0)), 1'b0);
    send_byte(8'h00, 1'b1);

    // random phases with different idling
    for (phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 3) ? 26 : 71) : 0;
      recv_stall_pct = (phase == 2 || phase == 3) ? ((phase == 3) ? 26 : 71) : 0;
      for (i = 0; i < 30; i++) begin
        if ($urandom_range(3, 0) == 0) alpha = 8'($urandom_range(255, 0));
        else alpha = 8'($urandom_range(3, 0));
        send_byte(alpha, $urandom_range(19, 0) == 0);
        if (i == 15) wait_drained();
      end
      send_byte(8'($urandom_range(255, 0)), 1'b1);
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0 && expected_codes.size() == 0 && typed_codes.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

// File: sim.f
+incdir+rtl
rtl/lzw_pkg.sv
rtl/lzw_if.sv
rtl/lzw_front.sv
rtl/lzw_core.sv
rtl/lzw_variable_width_encoder_top.sv
sim/testbench.sv
